[design/utf8_byte_stream_decoder_top_defines.svh]
// Assertion macros shared by the UTF-8 byte stream decoder RTL
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UBSD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define UBSD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ubsd_pkg.sv]
// Package: widths, constants and transaction types of the UTF-8 decoder
`default_nettype none
package ubsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned REM_W   = 2;

  localparam logic [BYTE_W-1:0] LEAD_MULTI_BIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_THREE_BIT = 8'h20;
  localparam logic [BYTE_W-1:0] LEAD_FOUR_BIT  = 8'h10;
  localparam logic [BYTE_W-1:0] LEAD_BAD_BIT   = 8'h08;
  localparam logic [BYTE_W-1:0] MASK_TWO       = 8'h1f;
  localparam logic [BYTE_W-1:0] MASK_CONT      = 8'h3f;
  localparam logic [BYTE_W-1:0] MASK_THREE     = 8'h0f;
  localparam logic [BYTE_W-1:0] MASK_FOUR      = 8'h07;

  localparam logic [CODE_W-1:0]  SUBST_CHAR = CODE_W'(63);  // '?'
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // Byte transaction held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } byte_item_t;

  // Result transaction held in the output register
  typedef struct packed {
    logic [CODE_W-1:0]  code_point;
    logic               is_replacement;
    logic               last;
    logic [COUNT_W-1:0] char_count;
  } result_t;

endpackage
`default_nettype wire

[design/ubsd_in_reg.sv]
// Input register: holds one byte transaction until the decode step takes it
`default_nettype none
module ubsd_in_reg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ubsd_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire                          in_end_of_string,
  input  wire                          take,
  output logic                         item_valid,
  output ubsd_pkg::byte_item_t         item
);
  import ubsd_pkg::*;

  logic       valid_r, valid_nxt;
  byte_item_t item_r;
  logic       in_fire;

  assign in_ready   = !valid_r || take;
  assign in_fire    = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.data_byte     <= in_data_byte;
      item_r.end_of_string <= in_end_of_string;
    end
  end

endmodule
`default_nettype wire

[design/ubsd_core.sv]
// Decode step: sequence state, character count and one-byte update logic
`default_nettype none
`include "utf8_byte_stream_decoder_top_defines.svh"
module ubsd_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   four_byte_enable,
  input  wire                   item_valid,
  input  ubsd_pkg::byte_item_t  item,
  input  wire                   out_free,
  output logic                  take,
  output logic                  res_load,
  output ubsd_pkg::result_t     res
);
  import ubsd_pkg::*;

  logic [CODE_W-1:0]  partial_r, partial_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [BYTE_W-1:0]  b;
  logic [CODE_W-1:0]  p_a;     // partial after this byte
  logic [REM_W-1:0]   r_a;     // remaining after this byte
  logic               done_a;
  logic               subst;
  logic               done;
  logic [CODE_W-1:0]  p_fin;   // padded with zeros on early end of string
  logic [COUNT_W-1:0] count_inc;

  assign b = item.data_byte;

  always_comb begin
    p_a    = partial_r;
    r_a    = rem_r;
    done_a = 1'b0;
    subst  = 1'b0;
    if (rem_r != '0) begin
      p_a    = {partial_r[CODE_W-7:0], b[5:0]};
      r_a    = rem_r - REM_W'(1);
      done_a = (r_a == '0);
    end else if ((b & LEAD_MULTI_BIT) == '0) begin
      p_a    = CODE_W'(b);
      done_a = 1'b1;
    end else if ((b & LEAD_THREE_BIT) == '0) begin
      p_a = CODE_W'(b & MASK_TWO);
      r_a = REM_W'(1);
    end else if ((b & LEAD_FOUR_BIT) == '0) begin
      p_a = CODE_W'(b & MASK_THREE);
      r_a = REM_W'(2);
    end else if (((b & LEAD_BAD_BIT) == '0) && four_byte_enable) begin
      p_a = CODE_W'(b & MASK_FOUR);
      r_a = REM_W'(3);
    end else begin
      subst  = 1'b1;
      done_a = 1'b1;
    end
  end

  // early end of string: shift in six zero bits per missing byte
  always_comb begin
    case (r_a)
      2'd0:    p_fin = p_a;
      2'd1:    p_fin = {p_a[CODE_W-7:0],  6'b0};
      2'd2:    p_fin = {p_a[CODE_W-13:0], 12'b0};
      2'd3:    p_fin = {p_a[CODE_W-19:0], 18'b0};
      default: p_fin = p_a;
    endcase
  end

  assign done      = done_a || item.end_of_string;
  assign take      = item_valid && (!done || out_free);
  assign res_load  = item_valid && done && out_free;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);

  always_comb begin
    res.code_point     = subst ? SUBST_CHAR : p_fin;
    res.is_replacement = subst;
    res.last           = item.end_of_string;
    res.char_count     = subst ? count_r : count_inc;
  end

  always_comb begin
    partial_nxt = partial_r;
    rem_nxt     = rem_r;
    count_nxt   = count_r;
    if (take) begin
      if (done) begin
        partial_nxt = '0;
        rem_nxt     = '0;
        count_nxt   = item.end_of_string ? '0 : res.char_count;
      end else begin
        partial_nxt = p_a;
        rem_nxt     = r_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      rem_r     <= '0;
      count_r   <= '0;
    end else begin
      partial_r <= partial_nxt;
      rem_r     <= rem_nxt;
      count_r   <= count_nxt;
    end
  end

  `UBSD_ASSERT_NEXT(a_eos_clears, clk, rst_n, take && item.end_of_string,
    (rem_r == '0) && (count_r == '0) && (partial_r == '0), "string state not cleared")
  `UBSD_ASSERT_NOW(a_last_cont_done, clk, rst_n, take && (rem_r == REM_W'(1)),
    res_load, "final continuation byte gave no result")
  `UBSD_ASSERT_NEXT(a_count_monotonic, clk, rst_n, take && !item.end_of_string,
    count_r >= $past(count_r), "character count went down inside a string")

endmodule
`default_nettype wire

[design/ubsd_out_reg.sv]
// Output register: holds one result transaction until the sink takes it
`default_nettype none
module ubsd_out_reg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          res_load,
  input  ubsd_pkg::result_t            res,
  output logic                         out_free,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ubsd_pkg::CODE_W-1:0]  out_code_point,
  output logic                         out_is_replacement,
  output logic                         out_last,
  output logic [ubsd_pkg::COUNT_W-1:0] out_char_count
);
  import ubsd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_comb begin
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_code_point     = res_r.code_point;
  assign out_is_replacement = res_r.is_replacement;
  assign out_last           = res_r.last;
  assign out_char_count     = res_r.char_count;

endmodule
`default_nettype wire

[design/utf8_byte_stream_decoder_top.sv]
// Top level of the lax UTF-8 byte stream decoder
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, data byte, end of string  | sink
//  out     | out_valid/out_ready, code point, flags, count| source
//  cfg     | cfg_valid/cfg_ready, four-byte enable        | sink
//
// One byte transaction per cycle sustained while the output is not stalled;
// a byte waits in the input register, its result in the output register.
// Only the single-pass decode sits between the two registers.
// Synchronous active-low reset; four-byte decoding is enabled out of reset.
// A stalled output blocks only bytes that complete a character; others pass.
// cfg_ready is always high; write only while the decoder is idle.
`default_nettype none
module utf8_byte_stream_decoder_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ubsd_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire                          in_end_of_string,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ubsd_pkg::CODE_W-1:0]  out_code_point,
  output logic                         out_is_replacement,
  output logic                         out_last,
  output logic [ubsd_pkg::COUNT_W-1:0] out_char_count,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_four_byte_enable
);
  import ubsd_pkg::*;

  logic       four_byte_enable_r, four_byte_enable_nxt;
  logic       item_valid;
  byte_item_t item;
  logic       take;
  logic       res_load;
  result_t    res;
  logic       out_free;

  // configuration register
  assign cfg_ready = 1'b1;

  always_comb begin
    four_byte_enable_nxt = four_byte_enable_r;
    if (cfg_valid && cfg_ready) begin
      four_byte_enable_nxt = cfg_four_byte_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_byte_enable_r <= 1'b1;
    end else begin
      four_byte_enable_r <= four_byte_enable_nxt;
    end
  end

  // input register: byte transaction waits here for the decode step
  ubsd_in_reg u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .take             (take),
    .item_valid       (item_valid),
    .item             (item)
  );

  // decode step: updates sequence state, emits a result on completion
  ubsd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .four_byte_enable (four_byte_enable_r),
    .item_valid       (item_valid),
    .item             (item),
    .out_free         (out_free),
    .take             (take),
    .res_load         (res_load),
    .res              (res)
  );

  // output register: parts the decode step from the result sink
  ubsd_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_load           (res_load),
    .res                (res),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_point     (out_code_point),
    .out_is_replacement (out_is_replacement),
    .out_last           (out_last),
    .out_char_count     (out_char_count)
  );

endmodule
`default_nettype wire

[test/utf8_decode_checker.sv]
// Checker for the UTF-8 decoder: predicts each character transaction and compares it
`default_nettype none
module utf8_decode_checker
  import ubsd_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire [BYTE_W-1:0]   in_data_byte,
  input  wire                in_end_of_string,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire [CODE_W-1:0]   out_code_point,
  input  wire                out_is_replacement,
  input  wire                out_last,
  input  wire [COUNT_W-1:0]  out_char_count,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire                cfg_four_byte_enable,
  output int unsigned        fail_count,
  output int unsigned        pending
);

  result_t             expected_chars[$];
  logic [CODE_W-1:0]   code_acc;
  logic [REM_W-1:0]    cont_left;
  logic [COUNT_W-1:0]  string_chars;
  logic                four_en;
  int unsigned         mismatch_total;

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display({"%0t %s: expected cp=%h repl=%b last=%b count=%0d,",
                " got cp=%h repl=%b last=%b count=%0d"},
               $realtime, what, want.code_point, want.is_replacement, want.last, want.char_count,
               got.code_point, got.is_replacement, got.last, got.char_count);
  endtask

  // One byte through the decoder model; queues a character when one completes
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eos);
    logic    done;
    logic    subst;
    result_t r;
    done  = 1'b0;
    subst = 1'b0;
    r     = '0;
    if (cont_left != 0) begin
      // open sequence: any byte is a continuation
      code_acc  = {code_acc[CODE_W-7:0], b[5:0]};
      cont_left = cont_left - 1'b1;
      done      = (cont_left == 0);
    end else if ((b & LEAD_MULTI_BIT) == 0) begin
      code_acc = CODE_W'(b);
      done     = 1'b1;
    end else if ((b & LEAD_THREE_BIT) == 0) begin
      code_acc  = CODE_W'(b & MASK_TWO);
      cont_left = 2'd1;
    end else if ((b & LEAD_FOUR_BIT) == 0) begin
      code_acc  = CODE_W'(b & MASK_THREE);
      cont_left = 2'd2;
    end else if ((b & LEAD_BAD_BIT) == 0 && four_en) begin
      code_acc  = CODE_W'(b & MASK_FOUR);
      cont_left = 2'd3;
    end else begin
      subst = 1'b1;
      done  = 1'b1;
    end

    // truncated at end of string: pad missing bits with zero
    if (eos && !done) begin
      code_acc  = code_acc << (6 * int'(cont_left));
      cont_left = '0;
      done      = 1'b1;
    end

    if (done) begin
      if (subst) begin
        r.code_point = SUBST_CHAR;
      end else begin
        r.code_point = code_acc;
        if (string_chars != COUNT_MAX) string_chars++;
      end
      r.is_replacement = subst;
      r.last           = eos;
      r.char_count     = string_chars;
      expected_chars.push_back(r);
      code_acc  = '0;
      cont_left = '0;
      if (eos) string_chars = '0;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      code_acc     = '0;
      cont_left    = '0;
      string_chars = '0;
      four_en      = 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        got.code_point     = out_code_point;
        got.is_replacement = out_is_replacement;
        got.last           = out_last;
        got.char_count     = out_char_count;
        if (expected_chars.size() == 0) begin
          note_mismatch("character with none pending", '0, got);
        end else begin
          want = expected_chars.pop_front();
          if (got.code_point !== want.code_point || got.is_replacement !== want.is_replacement ||
              got.last !== want.last || got.char_count !== want.char_count)
            note_mismatch("character mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) four_en = cfg_four_byte_enable;
      if (in_valid && in_ready) decode_byte(in_data_byte, in_end_of_string);
    end
    pending    <= expected_chars.size();
    fail_count <= mismatch_total;
  end

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench top for the UTF-8 byte stream decoder: stimulus, back-pressure and verdict
`default_nettype none
module tb;
  import ubsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;       // two-stage pipe plus margin
  localparam int unsigned LONG_STALL    = 100;     // receiver hold-off under pressure

  // receiver back-pressure patterns
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;
  // kinds of character the random part builds
  typedef enum int {CH_ASCII, CH_TWO, CH_THREE, CH_FOUR, CH_NOISE} char_kind_e;

  logic                clk;
  logic                rst_n                = 1'b0;
  logic                in_valid             = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_data_byte         = '0;
  logic                in_end_of_string     = 1'b0;
  logic                out_valid;
  logic                out_ready            = 1'b0;
  logic [CODE_W-1:0]   out_code_point;
  logic                out_is_replacement;
  logic                out_last;
  logic [COUNT_W-1:0]  out_char_count;
  logic                cfg_valid            = 1'b0;
  logic                cfg_ready;
  logic                cfg_four_byte_enable = 1'b0;

  int unsigned fail_count;
  int unsigned pending;

  // sender state
  bit          gaps_on        = 1'b0;
  int unsigned burst_left     = 0;
  int unsigned bytes_sent     = 0;
  logic        pressure_phase = 1'b0;

  utf8_byte_stream_decoder_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_end_of_string     (in_end_of_string),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_code_point       (out_code_point),
    .out_is_replacement   (out_is_replacement),
    .out_last             (out_last),
    .out_char_count       (out_char_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_four_byte_enable (cfg_four_byte_enable)
  );

  // The checker sits beside the block, watching all three channels
  utf8_decode_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_end_of_string     (in_end_of_string),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_code_point       (out_code_point),
    .out_is_replacement   (out_is_replacement),
    .out_last             (out_last),
    .out_char_count       (out_char_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_four_byte_enable (cfg_four_byte_enable),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one byte transaction and hold it until taken. Valid stays high into
  // the next transaction unless the burst has run out and a gap is drawn.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    int unsigned gap;
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        // a zero gap gives a long unbroken stretch
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Drain: every predicted character back, then let bytes that make no
  // character (open leads) clear the pipe before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_four_byte_enable(input logic v);
    cfg_valid            <= 1'b1;
    cfg_four_byte_enable <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] rand_cont();
    // mostly proper 10xxxxxx, now and then any byte at all
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // One character of random content; the last of a string may be cut short
  task automatic send_char(input bit last_char);
    logic [BYTE_W-1:0] seq [4];
    char_kind_e        kind;
    int unsigned       pick;
    int unsigned       n;
    pick = $urandom_range(0, 19);
    if (pick < 8)       kind = CH_ASCII;
    else if (pick < 11) kind = CH_TWO;
    else if (pick < 14) kind = CH_THREE;
    else if (pick < 17) kind = CH_FOUR;
    else                kind = CH_NOISE;

    seq[0] = BYTE_W'($urandom);
    for (int i = 1; i < 4; i++) seq[i] = rand_cont();
    case (kind)
      CH_ASCII: begin
        seq[0][7] = 1'b0;
        n = 1;
      end
      CH_TWO: begin
        seq[0][7] = 1'b1; seq[0][5] = 1'b0;
        n = 2;
      end
      CH_THREE: begin
        seq[0][7] = 1'b1; seq[0][5] = 1'b1; seq[0][4] = 1'b0;
        n = 3;
      end
      CH_FOUR: begin
        seq[0][7] = 1'b1; seq[0][5] = 1'b1; seq[0][4] = 1'b1; seq[0][3] = 1'b0;
        n = 4;
      end
      default: n = 1;
    endcase

    // broken sequence: end of string lands mid-character
    if (last_char && n > 1 && $urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) send_byte(seq[i], last_char && (i == n - 1));
  endtask

  // Random strings until the byte quota is met; optionally a pressure burst
  task automatic run_strings(input int unsigned quota, input bit with_pressure);
    int unsigned start;
    int unsigned nchars;
    bit          pressed;
    start   = bytes_sent;
    pressed = 1'b0;
    gaps_on = 1'b1;
    while (bytes_sent - start < quota) begin
      if (with_pressure && !pressed && bytes_sent - start > quota / 2) begin
        // receiver holds off while the sender keeps offering back to back
        pressed        = 1'b1;
        gaps_on        = 1'b0;
        pressure_phase <= 1'b1;
        for (int i = 0; i < 60; i++) send_byte({1'b0, 7'($urandom)}, i == 59);
        pressure_phase <= 1'b0;
        gaps_on        = 1'b1;
      end
      nchars = $urandom_range(1, 12);
      for (int c = 0; c < nchars; c++) send_char(c == nchars - 1);
    end
    gaps_on = 1'b0;
  endtask

  // Receiver: segments of random length, each with its own ready pattern,
  // and one long hold-off when the pressure burst starts.
  initial begin : receiver
    int unsigned seg_left;
    int unsigned stall_left;
    rx_mode_e    seg_mode;
    bit          held;
    seg_left   = 0;
    stall_left = 0;
    seg_mode   = RX_ALWAYS;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_phase && !held) begin
        held       = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          seg_mode = rx_mode_e'($urandom_range(0, 3));
        end
        seg_left--;
        case (seg_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= !out_ready;
        endcase
      end
    end
  end

  // Watchdog: a hung block or a lost transaction ends here
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, four-byte decoding on as out of reset
    send_byte(8'h00, 1'b0);                    // ASCII bottom
    send_byte(8'h7f, 1'b0);                    // ASCII top
    send_byte(8'hc2, 1'b0);                    // two-byte
    send_byte(8'ha9, 1'b0);
    send_byte(8'hdf, 1'b0);                    // two-byte, all ones
    send_byte(8'hbf, 1'b0);
    send_byte(8'he2, 1'b0);                    // three-byte
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hf0, 1'b0);                    // four-byte
    send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hf8, 1'b0);                    // bit 3 set: replacement
    send_byte(8'hff, 1'b0);                    // replacement
    send_byte(8'h80, 1'b0);                    // stray continuation acts as a lead
    send_byte(8'hff, 1'b0);                    // continuation upper bits ignored
    send_byte(8'he2, 1'b0);                    // string ends mid-sequence
    send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);                    // one-character string
    send_byte(8'hf7, 1'b1);                    // lead alone at end, zero padded
    send_byte(8'hff, 1'b1);                    // replacement as the last character
    settle();

    // Four-byte decoding off: those leads become replacements
    write_four_byte_enable(1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'hf7, 1'b1);
    settle();

    write_four_byte_enable(1'b1);
    run_strings(200, 1'b1);
    settle();

    write_four_byte_enable(1'b0);
    run_strings(180, 1'b0);
    settle();

    write_four_byte_enable(1'b1);
    run_strings(170, 1'b0);
    settle();

    if (fail_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
